/* rtl/core/sllc_pkg.sv */
// ----------------------------------------------------------------------------
// Scalable layer list checker package
// Word types, layout codes and loudspeaker count tables shared by the checker.
// ----------------------------------------------------------------------------
package sllc_pkg;

   localparam logic [3:0] LAYOUT_LAST_KNOWN = 4'd8;
   localparam logic [3:0] LAYOUT_BINAURAL   = 4'd9;
   localparam logic [3:0] LAYOUT_EXPANDED   = 4'd15;
   localparam logic [2:0] LAYER_LIMIT       = 3'd6;

   typedef struct packed {
      logic [3:0]  layout_code;
      logic [7:0]  layer_substreams;
      logic [7:0]  layer_coupled;
      logic [2:0]  declared_layers;
      logic [15:0] element_substreams;
      logic        first_layer;
      logic        last_layer;
   } sllc_req_type;

   typedef struct packed {
      logic order_error;
      logic duplicate_error;
      logic subs_mismatch;
      logic coupled_mismatch;
      logic zero_subs_error;
      logic coupled_over_error;
      logic total_mismatch;
      logic too_many_layers;
      logic expanded_multi_error;
      logic binaural_multi_error;
   } sllc_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] subs;
      logic [2:0] coup;
   } sllc_expect_type;

   function automatic logic [2:0] surround_count(input logic [3:0] code);
      case (code)
         4'd0:    surround_count = 3'd1;
         4'd1:    surround_count = 3'd2;
         4'd2:    surround_count = 3'd5;
         4'd3:    surround_count = 3'd5;
         4'd4:    surround_count = 3'd5;
         4'd5:    surround_count = 3'd7;
         4'd6:    surround_count = 3'd7;
         4'd7:    surround_count = 3'd7;
         4'd8:    surround_count = 3'd3;
         default: surround_count = 3'd0;
      endcase
   endfunction

   function automatic logic lfe_count(input logic [3:0] code);
      lfe_count = (code >= 4'd2) && (code <= LAYOUT_LAST_KNOWN);
   endfunction

   function automatic logic [2:0] height_count(input logic [3:0] code);
      case (code)
         4'd3:    height_count = 3'd2;
         4'd4:    height_count = 3'd4;
         4'd6:    height_count = 3'd2;
         4'd7:    height_count = 3'd4;
         4'd8:    height_count = 3'd2;
         default: height_count = 3'd0;
      endcase
   endfunction

   function automatic logic [2:0] first_subs(input logic [3:0] code);
      case (code)
         4'd0:    first_subs = 3'd1;
         4'd1:    first_subs = 3'd1;
         4'd2:    first_subs = 3'd4;
         4'd3:    first_subs = 3'd5;
         4'd4:    first_subs = 3'd6;
         4'd5:    first_subs = 3'd5;
         4'd6:    first_subs = 3'd6;
         4'd7:    first_subs = 3'd7;
         4'd8:    first_subs = 3'd4;
         default: first_subs = 3'd0;
      endcase
   endfunction

   function automatic logic [2:0] first_coup(input logic [3:0] code);
      case (code)
         4'd0:    first_coup = 3'd0;
         4'd1:    first_coup = 3'd1;
         4'd2:    first_coup = 3'd2;
         4'd3:    first_coup = 3'd3;
         4'd4:    first_coup = 3'd4;
         4'd5:    first_coup = 3'd3;
         4'd6:    first_coup = 3'd4;
         4'd7:    first_coup = 3'd5;
         4'd8:    first_coup = 3'd2;
         default: first_coup = 3'd0;
      endcase
   endfunction

endpackage

/* rtl/core/sllc_expect.sv */
// ----------------------------------------------------------------------------
// Scalable layer list checker: expected counts
// Derives the substream and coupled counts expected for a layer from its
// layout and the layout of the layer before it.
// ----------------------------------------------------------------------------
module sllc_expect
   import sllc_pkg::*;
(
   input  logic            has_prev,
   input  logic [3:0]      earlier_layout,
   input  logic [3:0]      layout,
   output sllc_expect_type expect_word
);

   logic [2:0] xc, xp, zc, zp, dz, s, k;
   logic       yc, yp, ok;

   assign xc = surround_count(layout);
   assign xp = surround_count(earlier_layout);
   assign yc = lfe_count(layout);
   assign yp = lfe_count(earlier_layout);
   assign zc = height_count(layout);
   assign zp = height_count(earlier_layout);
   assign dz = zc - zp;

   always_comb begin
      ok = 1'b1;
      s  = 3'd0;
      k  = 3'd0;
      if (layout > LAYOUT_LAST_KNOWN) begin
         ok = 1'b0;
      end else if (!has_prev) begin
         s = first_subs(layout);
         k = first_coup(layout);
      end else if (earlier_layout > LAYOUT_LAST_KNOWN) begin
         ok = 1'b0;
      end else begin
         if (xc > xp) begin
            if (xp == 3'd2 && xc == 3'd5) begin
               s = s + 3'd2;
               k = k + 3'd1;
            end else if (xp == 3'd5 && xc == 3'd7) begin
               s = s + 3'd1;
               k = k + 3'd1;
            end else if (xp == 3'd1 && xc == 3'd2) begin
               s = s + 3'd1;
            end else if (xp == 3'd3 && xc == 3'd5) begin
               s = s + 3'd1;
               k = k + 3'd1;
            end else begin
               ok = 1'b0;
            end
         end
         if (yc && !yp) begin
            s = s + 3'd1;
         end
         if (zc > zp) begin
            if (dz == 3'd2) begin
               s = s + 3'd1;
               k = k + 3'd1;
            end else if (dz == 3'd4) begin
               s = s + 3'd2;
               k = k + 3'd2;
            end else begin
               ok = 1'b0;
            end
         end
      end
   end

   assign expect_word.valid = ok;
   assign expect_word.subs  = s;
   assign expect_word.coup  = k;

endmodule

/* rtl/core/scalable_layer_list_checker_top.sv */
// ----------------------------------------------------------------------------
// Scalable layer list checker
// Checks the layer list of a channel-based audio element, one layer a word.
// ----------------------------------------------------------------------------
// The req channel carries one layer per word, with first_layer marking the
// start of an element and last_layer its final stored layer. The rsp channel
// returns one word of error flags per layer, in order.
// A word passes an input register and then a result register before its flag
// word is offered on rsp. The checks are table lookups and compares against the
// registered previous layout and running substream sum, so one layer is
// accepted in every cycle while req_stall is low.
// Reset clears the previous layout, the running sum and the seen flags, and
// empties both registers. When the receiver stalls, the result word holds and
// the input register fills; req_stall rises only when both are occupied.
// ----------------------------------------------------------------------------
module scalable_layer_list_checker_top
   import sllc_pkg::*;
#(
   parameter int MAX_LAYERS = 7
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sllc_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sllc_rsp_type rsp_word
);

   localparam int SUM_LIMIT = MAX_LAYERS * 255;
   localparam int SUM_W     = $clog2(SUM_LIMIT + 1);

   logic            s1_valid_ff, s1_valid_in;
   sllc_req_type    s1_word_ff;
   logic            out_valid_ff, out_valid_in;
   sllc_rsp_type    out_word_ff, out_word_in;

   logic [3:0]      earlier_layout_ff, earlier_layout_in;
   logic            prev_present_ff, prev_present_in;
   logic [3:0]      known_layout_ff, known_layout_in;
   logic            known_present_ff, known_present_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic            seen_exp_ff, seen_exp_in;
   logic            seen_bin_ff, seen_bin_in;

   logic            out_load, advance, accept;
   logic            first, last, known_cur, multi;
   logic [SUM_W-1:0] sum_base;
   logic [SUM_W:0]  sum_wide;
   logic [2:0]      xc, xp, zc, zp;
   logic            yc, yp;
   sllc_expect_type exp_word;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_load;
   assign req_stall = s1_valid_ff && !out_load;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   assign first     = s1_word_ff.first_layer;
   assign last      = s1_word_ff.last_layer;
   assign known_cur = s1_word_ff.layout_code <= LAYOUT_LAST_KNOWN;
   assign multi     = s1_word_ff.declared_layers > 3'd1;

   sllc_expect u_expect (
      .has_prev       (prev_present_ff && !first),
      .earlier_layout (earlier_layout_ff),
      .layout         (s1_word_ff.layout_code),
      .expect_word    (exp_word)
   );

   assign xc = surround_count(s1_word_ff.layout_code);
   assign xp = surround_count(known_layout_ff);
   assign yc = lfe_count(s1_word_ff.layout_code);
   assign yp = lfe_count(known_layout_ff);
   assign zc = height_count(s1_word_ff.layout_code);
   assign zp = height_count(known_layout_ff);

   assign sum_base = first ? '0 : sum_ff;
   assign sum_wide = {1'b0, sum_base}
                   + {{(SUM_W + 1 - 8){1'b0}}, s1_word_ff.layer_substreams};

   always_comb begin
      logic order_chk;
      order_chk = known_cur && multi && known_present_ff && !first
                  && (known_layout_ff <= LAYOUT_LAST_KNOWN);

      sum_in = (sum_wide > (SUM_W + 1)'(SUM_LIMIT)) ? SUM_W'(SUM_LIMIT)
                                                    : sum_wide[SUM_W-1:0];
      seen_exp_in = (!first && seen_exp_ff)
                    || (s1_word_ff.layout_code == LAYOUT_EXPANDED);
      seen_bin_in = (!first && seen_bin_ff)
                    || (s1_word_ff.layout_code == LAYOUT_BINAURAL);
      earlier_layout_in = s1_word_ff.layout_code;
      prev_present_in   = 1'b1;
      known_layout_in  = known_cur ? s1_word_ff.layout_code
                                   : (first ? 4'd0 : known_layout_ff);
      known_present_in = known_cur || (!first && known_present_ff);

      out_word_in.order_error     = order_chk && ((xc < xp) || (!yc && yp) || (zc < zp));
      out_word_in.duplicate_error = order_chk && (xc == xp) && (yc == yp) && (zc == zp);
      out_word_in.subs_mismatch   = exp_word.valid
                                    && (s1_word_ff.layer_substreams != {5'd0, exp_word.subs});
      out_word_in.coupled_mismatch = exp_word.valid
                                     && (s1_word_ff.layer_coupled != {5'd0, exp_word.coup});
      out_word_in.zero_subs_error    = s1_word_ff.layer_substreams == 8'd0;
      out_word_in.coupled_over_error =
         s1_word_ff.layer_coupled > s1_word_ff.layer_substreams;
      out_word_in.total_mismatch  = last
         && ({{(16 - SUM_W){1'b0}}, sum_in} != s1_word_ff.element_substreams);
      out_word_in.too_many_layers = last && (s1_word_ff.declared_layers > LAYER_LIMIT);
      out_word_in.expanded_multi_error =
         last && seen_exp_in && (s1_word_ff.declared_layers != 3'd1);
      out_word_in.binaural_multi_error =
         last && seen_bin_in && (s1_word_ff.declared_layers != 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         earlier_layout_ff <= 4'd0;
         prev_present_ff   <= 1'b0;
         known_layout_ff   <= 4'd0;
         known_present_ff  <= 1'b0;
         sum_ff            <= '0;
         seen_exp_ff       <= 1'b0;
         seen_bin_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            earlier_layout_ff <= earlier_layout_in;
            prev_present_ff   <= prev_present_in;
            known_layout_ff   <= known_layout_in;
            known_present_ff  <= known_present_in;
            sum_ff            <= sum_in;
            seen_exp_ff       <= seen_exp_in;
            seen_bin_ff       <= seen_bin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
      else $error("Input stalled while a register was free.");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("Advanced word did not reach the result register.");

   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_W'(SUM_LIMIT))
      else $error("Substream sum passed its saturation limit.");

   a_known_layout: assert property (@(posedge clock) disable iff (reset)
      known_present_ff |-> (known_layout_ff <= LAYOUT_LAST_KNOWN))
      else $error("Known previous layout is not a known layout.");

   a_order_dup_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_word_ff.order_error && out_word_ff.duplicate_error))
      else $error("Order and duplicate errors raised together.");

endmodule

/* tb/scalable_layer_list_checker_top_tb.sv */
// ----------------------------------------------------------------------------
// Scalable layer list checker testbench
// Sends layer words to the checker and compares every flag word it returns
// with flags worked out by a model of the layer rules kept in this bench.
// Directed tests cover the layout tables, order and duplicate checks,
// unknown layouts, count extremes and sum saturation. Random elements follow,
// mostly well formed with occasional damage and noise words, while both
// sides pause at random and the receiver once holds off for a long stretch.
// ----------------------------------------------------------------------------
module scalable_layer_list_checker_top_tb;
   import sllc_pkg::*;

   localparam int MAX_LAYERS   = 7;
   localparam int SUM_LIMIT    = MAX_LAYERS * 255;
   localparam int RANDOM_ITEMS = 340;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 400;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   sllc_req_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   sllc_rsp_type rsp_word;

   logic [2:0] surround_tab [9] = '{3'd1, 3'd2, 3'd5, 3'd5, 3'd5, 3'd7, 3'd7, 3'd7, 3'd3};
   logic       lfe_tab      [9] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
   logic [2:0] height_tab   [9] = '{3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd0, 3'd2, 3'd4, 3'd2};
   logic [2:0] base_subs    [9] = '{3'd1, 3'd1, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd7, 3'd4};
   logic [2:0] base_coup    [9] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd5, 3'd2};

   string flag_names [10] = '{"order_error", "duplicate_error", "subs_mismatch",
      "coupled_mismatch", "zero_subs_error", "coupled_over_error", "total_mismatch",
      "too_many_layers", "expanded_multi_error", "binaural_multi_error"};

   logic [3:0]  last_layout   = 4'd0;
   logic        last_present  = 1'b0;
   logic [3:0]  known_layout  = 4'd0;
   logic        known_present = 1'b0;
   logic [10:0] running_sum   = 11'd0;
   logic        saw_expanded  = 1'b0;
   logic        saw_binaural  = 1'b0;

   sllc_rsp_type expected_flags [$];
   int          error_count  = 0;
   int          cycle_count  = 0;
   int          layers_sent  = 0;
   int          burst_left   = 0;
   logic        steady_sender = 1'b0;
   logic        hold_request  = 1'b0;
   int          hold_left     = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int          stall_phase   = 0;

   scalable_layer_list_checker_top #(
      .MAX_LAYERS(MAX_LAYERS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("scalable_layer_list_checker_top_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic layer_counts(input logic has_prev, input logic [3:0] prev_code,
                                         input logic [3:0] code, output logic [3:0] subs,
                                         output logic [3:0] coup);
      logic [2:0] a;
      logic [2:0] b;
      logic [2:0] dz;
      subs = '0;
      coup = '0;
      if (code > LAYOUT_LAST_KNOWN) return 1'b0;
      if (!has_prev) begin
         subs = {1'b0, base_subs[code]};
         coup = {1'b0, base_coup[code]};
         return 1'b1;
      end
      if (prev_code > LAYOUT_LAST_KNOWN) return 1'b0;
      a = surround_tab[prev_code];
      b = surround_tab[code];
      if (b > a) begin
         if (a == 3'd2 && b == 3'd5) begin
            subs += 4'd2;
            coup += 4'd1;
         end else if ((a == 3'd5 && b == 3'd7) || (a == 3'd3 && b == 3'd5)) begin
            subs += 4'd1;
            coup += 4'd1;
         end else if (a == 3'd1 && b == 3'd2) begin
            subs += 4'd1;
         end else begin
            return 1'b0;
         end
      end
      if (lfe_tab[code] && !lfe_tab[prev_code]) subs += 4'd1;
      if (height_tab[code] > height_tab[prev_code]) begin
         dz = height_tab[code] - height_tab[prev_code];
         if (dz == 3'd2) begin
            subs += 4'd1;
            coup += 4'd1;
         end else if (dz == 3'd4) begin
            subs += 4'd2;
            coup += 4'd2;
         end else begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic sllc_rsp_type predict_layer_flags(input sllc_req_type w);
      sllc_rsp_type f;
      logic [3:0]   es;
      logic [3:0]   ec;
      logic [3:0]   p;
      logic [11:0]  acc;
      f = '0;
      if (w.first_layer) begin
         last_layout   = '0;
         last_present  = 1'b0;
         known_layout  = '0;
         known_present = 1'b0;
         running_sum   = '0;
         saw_expanded  = 1'b0;
         saw_binaural  = 1'b0;
      end
      if (w.layout_code <= LAYOUT_LAST_KNOWN && w.declared_layers > 3'd1 && known_present) begin
         p = known_layout;
         f.order_error = surround_tab[w.layout_code] < surround_tab[p]
                      || lfe_tab[w.layout_code] < lfe_tab[p]
                      || height_tab[w.layout_code] < height_tab[p];
         f.duplicate_error = surround_tab[w.layout_code] == surround_tab[p]
                          && lfe_tab[w.layout_code] == lfe_tab[p]
                          && height_tab[w.layout_code] == height_tab[p];
      end
      if (layer_counts(last_present, last_layout, w.layout_code, es, ec)) begin
         f.subs_mismatch    = w.layer_substreams != {4'd0, es};
         f.coupled_mismatch = w.layer_coupled != {4'd0, ec};
      end
      f.zero_subs_error    = w.layer_substreams == 8'd0;
      f.coupled_over_error = w.layer_coupled > w.layer_substreams;
      acc = {1'b0, running_sum} + {4'd0, w.layer_substreams};
      if (acc > SUM_LIMIT) acc = 12'(SUM_LIMIT);
      running_sum = acc[10:0];
      if (w.layout_code == LAYOUT_EXPANDED) saw_expanded = 1'b1;
      if (w.layout_code == LAYOUT_BINAURAL) saw_binaural = 1'b1;
      if (w.last_layer) begin
         f.total_mismatch       = {5'd0, running_sum} != w.element_substreams;
         f.too_many_layers      = w.declared_layers > LAYER_LIMIT;
         f.expanded_multi_error = saw_expanded && w.declared_layers != 3'd1;
         f.binaural_multi_error = saw_binaural && w.declared_layers != 3'd1;
      end
      if (w.layout_code <= LAYOUT_LAST_KNOWN) begin
         known_layout  = w.layout_code;
         known_present = 1'b1;
      end
      last_layout  = w.layout_code;
      last_present = 1'b1;
      return f;
   endfunction

   function automatic sllc_req_type make_layer(input logic [3:0] code, input logic [7:0] subs,
                                               input logic [7:0] coup, input logic [2:0] layers,
                                               input logic [15:0] total, input logic first,
                                               input logic last);
      sllc_req_type w;
      w.layout_code        = code;
      w.layer_substreams   = subs;
      w.layer_coupled      = coup;
      w.declared_layers    = layers;
      w.element_substreams = total;
      w.first_layer        = first;
      w.last_layer         = last;
      return w;
   endfunction

   task automatic send_layer(input sllc_req_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_flags = {expected_flags, predict_layer_flags(w)};
      layers_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady_sender && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic send_noise_layer();
      logic [63:0] r;
      r = {$urandom, $urandom};
      send_layer(r[40:0]);
   endtask

   // Builds a chain of growing layouts, optionally damages it, and sends it.
   task automatic send_element(input int want, input bit damage);
      logic [3:0]   codes [$];
      logic [3:0]   cand [$];
      logic [7:0]   subs [$];
      logic [7:0]   coup [$];
      logic [3:0]   cur;
      logic [3:0]   es;
      logic [3:0]   ec;
      logic [15:0]  total;
      logic [2:0]   declared;
      logic [3:0]   tmp;
      int           kind;
      int           idx;
      int           other;
      cur = 4'($urandom_range(0, 8));
      codes = {codes, cur};
      while (codes.size() < want) begin
         cand.delete();
         for (int c = 0; c <= 8; c++) begin
            if (layer_counts(1'b1, cur, c[3:0], es, ec)
                && surround_tab[c] >= surround_tab[cur] && lfe_tab[c] >= lfe_tab[cur]
                && height_tab[c] >= height_tab[cur]
                && !(surround_tab[c] == surround_tab[cur] && lfe_tab[c] == lfe_tab[cur]
                     && height_tab[c] == height_tab[cur]))
               cand = {cand, c[3:0]};
         end
         if (cand.size() == 0) break;
         cur = cand[$urandom_range(0, cand.size() - 1)];
         codes = {codes, cur};
      end
      kind = damage ? $urandom_range(0, 5) : -1;
      idx  = $urandom_range(0, codes.size() - 1);
      if (kind == 4) begin
         case ($urandom_range(0, 2))
            0:       codes[idx] = LAYOUT_BINAURAL;
            1:       codes[idx] = LAYOUT_EXPANDED;
            default: codes[idx] = 4'($urandom_range(10, 14));
         endcase
      end else if (kind == 5 && codes.size() > 1) begin
         other        = (idx + 1) % codes.size();
         tmp          = codes[idx];
         codes[idx]   = codes[other];
         codes[other] = tmp;
      end
      total = '0;
      foreach (codes[i]) begin
         if (layer_counts(i > 0, (i > 0) ? codes[i - 1] : 4'd0, codes[i], es, ec)) begin
            subs = {subs, {4'd0, es}};
            coup = {coup, {4'd0, ec}};
         end else begin
            subs = {subs, 8'($urandom_range(1, 8))};
            coup = {coup, 8'($urandom_range(0, 4))};
         end
      end
      if (kind == 0) subs[idx] = 8'($urandom_range(0, 255));
      if (kind == 1) coup[idx] = 8'($urandom_range(0, 255));
      foreach (subs[i]) total += {8'd0, subs[i]};
      declared = 3'(codes.size());
      if (kind == 2) total = 16'($urandom_range(0, 65535));
      if (kind == 3) declared = 3'($urandom_range(0, 7));
      foreach (codes[i])
         send_layer(make_layer(codes[i], subs[i], coup[i], declared, total,
                               i == 0, i == codes.size() - 1));
   endtask

   task automatic test_no_previous_layer();
      send_layer(make_layer(4'd2, 8'd4, 8'd2, 3'd1, 16'd4, 1'b0, 1'b1));
   endtask

   task automatic test_first_layer_table();
      send_layer(make_layer(4'd0, 8'd1, 8'd0, 3'd1, 16'd1, 1'b1, 1'b1));
      send_layer(make_layer(4'd4, 8'd6, 8'd4, 3'd1, 16'd6, 1'b1, 1'b1));
      send_layer(make_layer(LAYOUT_LAST_KNOWN, 8'd4, 8'd2, 3'd1, 16'd4, 1'b1, 1'b1));
      send_layer(make_layer(LAYOUT_BINAURAL, 8'd2, 8'd2, 3'd2, 16'd2, 1'b1, 1'b1));
      send_layer(make_layer(LAYOUT_EXPANDED, 8'd3, 8'd1, 3'd2, 16'd3, 1'b1, 1'b1));
   endtask

   task automatic test_scalable_chain();
      send_layer(make_layer(4'd0, 8'd1, 8'd0, 3'd4, 16'd6, 1'b1, 1'b0));
      send_layer(make_layer(4'd1, 8'd1, 8'd0, 3'd4, 16'd6, 1'b0, 1'b0));
      send_layer(make_layer(4'd2, 8'd3, 8'd1, 3'd4, 16'd6, 1'b0, 1'b0));
      send_layer(make_layer(4'd3, 8'd1, 8'd1, 3'd4, 16'd6, 1'b0, 1'b1));
   endtask

   task automatic test_order_and_duplicate();
      send_layer(make_layer(4'd5, 8'd5, 8'd3, 3'd3, 16'd5, 1'b1, 1'b0));
      send_layer(make_layer(4'd2, 8'd0, 8'd0, 3'd3, 16'd5, 1'b0, 1'b0));
      send_layer(make_layer(4'd2, 8'd0, 8'd0, 3'd3, 16'd5, 1'b0, 1'b1));
   endtask

   task automatic test_unknown_and_unsupported();
      send_layer(make_layer(4'd0, 8'd1, 8'd0, 3'd4, 16'd9, 1'b1, 1'b0));
      send_layer(make_layer(4'd5, 8'd3, 8'd2, 3'd4, 16'd9, 1'b0, 1'b0));
      send_layer(make_layer(4'd12, 8'd2, 8'd1, 3'd4, 16'd9, 1'b0, 1'b0));
      send_layer(make_layer(4'd3, 8'd3, 8'd1, 3'd4, 16'd9, 1'b0, 1'b1));
   endtask

   task automatic test_count_extremes();
      send_layer(make_layer(4'd3, 8'd0, 8'd255, 3'd7, 16'hFFFF, 1'b1, 1'b0));
      send_layer(make_layer(LAYOUT_EXPANDED, 8'd255, 8'd255, 3'd7, 16'hFFFF, 1'b0, 1'b1));
   endtask

   task automatic test_sum_saturation();
      for (int i = 0; i < 8; i++)
         send_layer(make_layer(4'd1, 8'd255, 8'd0, 3'd6, 16'(SUM_LIMIT), i == 0, i == 7));
   endtask

   task automatic test_random_elements();
      int start;
      start = layers_sent;
      while (layers_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_noise_layer();
         else
            send_element($urandom_range(1, 6), $urandom_range(0, 2) == 0);
      end
   endtask

   task automatic test_input_backpressure();
      steady_sender = 1'b1;
      hold_request  = 1'b1;
      repeat (15) send_element($urandom_range(2, 5), 1'b0);
      steady_sender = 1'b0;
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_flags.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (expected_flags.size() != 0)
         report_mismatch($sformatf("%0d flag words never arrived", expected_flags.size()));
   endtask

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_phase == 0) begin
            stall_mode  = stall_mode_type'($urandom_range(0, 3));
            stall_phase = $urandom_range(16, 160);
         end
         stall_phase--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= $urandom_range(0, 7) == 0;
            STALL_HEAVY: rsp_stall <= $urandom_range(0, 1) == 1;
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin : check_flags
      logic [9:0] got;
      logic [9:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_word;
         if (expected_flags.size() == 0) begin
            report_mismatch($sformatf("unexpected flag word %b", got));
         end else begin
            want = expected_flags.pop_front();
            for (int i = 0; i < 10; i++)
               if (got[9 - i] !== want[9 - i])
                  report_mismatch($sformatf("%s got %b expected %b",
                                            flag_names[i], got[9 - i], want[9 - i]));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_no_previous_layer();
      test_first_layer_table();
      test_scalable_chain();
      test_order_and_duplicate();
      test_unknown_and_unsupported();
      test_count_extremes();
      test_sum_saturation();
      test_random_elements();
      test_input_backpressure();
      test_random_elements();
      drain_results();
      if (error_count == 0)
         $display("scalable_layer_list_checker_top_tb passed");
      else
         $display("scalable_layer_list_checker_top_tb failed");
      $finish;
   end

endmodule
